/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the timer queue.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* hdl/stq_pkg.sv */
// Package for the sorted timer queue: widths, codes and the structs that
// pass between the queue cells and the top level. No dependencies.
package stq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_W        = 4;
    localparam int DELAY_W     = 32;
    localparam int MS_W        = 32;
    localparam int DL_W        = 42;
    localparam int WAKE_W      = 33;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int MS_TO_US    = 1000;

    // x/1000 as (x * RECIP_MUL) >> RECIP_SHIFT, exact for any 32-bit x
    localparam int                 RECIP_W     = 29;
    localparam logic [RECIP_W-1:0] RECIP_MUL   = 29'd274877907;
    localparam int                 RECIP_SHIFT = 38;
    localparam int                 PROD_W      = DELAY_W + RECIP_W;

    // operation selector
    localparam logic [FUNC_W-1:0] FUNC_REGISTER = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CANCEL   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_POP
    } cell_op_t;

    // one queue entry
    typedef struct packed {
        logic              valid;
        logic [DL_W-1:0]   dl;
        logic [WAKE_W-1:0] wake;
        logic [ID_W-1:0]   id;
    } entry_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        cell_op_t          op;
        logic [DL_W-1:0]   key_dl;
        logic [WAKE_W-1:0] key_wake;
        logic [ID_W-1:0]   key_id;
        logic [DL_W-1:0]   now_us;
    } cell_ctrl_t;

    // ripple from head toward tail
    typedef struct packed {
        logic              le;    // this cell (and all before) sort at or before the key
        logic              rm;    // handle matched here or earlier
        logic              due;   // this cell and all before are expired
        logic [WAKE_W-1:0] wake;  // wake value of the first entry that survives a tick
    } link_t;

endpackage

/* hdl/stq_div.sv */
// Divides a 32-bit delay by 1000 with a reciprocal multiply; the operand and the quotient are registered.
// Depends on stq_pkg.
module stq_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [stq_pkg::DELAY_W-1:0]  dividend,
    output logic [stq_pkg::DELAY_W-1:0]  quotient,
    output logic                         done
);

    logic [stq_pkg::DELAY_W-1:0]   arg_reg;
    logic [stq_pkg::DELAY_W-1:0]   quotient_reg;
    logic [stq_pkg::PROD_W-1:0]    product;
    logic                          run_reg;
    logic                          done_reg;

    // operands are 32 by 29 bits; the upper bits of the product hold the quotient
    assign product = stq_pkg::PROD_W'(arg_reg) * stq_pkg::PROD_W'(stq_pkg::RECIP_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= load;
            done_reg <= run_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            arg_reg <= dividend;
        end
        if (run_reg)
        begin
            quotient_reg <= stq_pkg::DELAY_W'(product >> stq_pkg::RECIP_SHIFT);
        end
    end

    assign quotient = quotient_reg;
    assign done     = done_reg;

endmodule

/* hdl/stq_cell.sv */
// One slot of the sorted timer queue; shifts entries with its neighbors.
// Depends on stq_pkg.
module stq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  stq_pkg::cell_ctrl_t ctrl,
    input  stq_pkg::entry_t     prev_entry,
    input  stq_pkg::entry_t     next_entry,
    input  stq_pkg::link_t      link_in,
    output stq_pkg::link_t      link_out,
    output stq_pkg::entry_t     entry
);

    logic                         valid_reg;
    logic [stq_pkg::DL_W-1:0]     dl_reg;
    logic [stq_pkg::WAKE_W-1:0]   wake_reg;
    logic [stq_pkg::ID_W-1:0]     id_reg;
    stq_pkg::entry_t              entry_next;
    logic                         le_own;
    logic                         match_own;
    logic                         due_own;

    assign entry = '{valid: valid_reg, dl: dl_reg, wake: wake_reg, id: id_reg};

    assign le_own    = valid_reg && (dl_reg <= ctrl.key_dl);
    assign match_own = valid_reg && (id_reg == ctrl.key_id);
    assign due_own   = valid_reg && (dl_reg <= ctrl.now_us);

    always_comb
    begin
        link_out.le   = le_own;
        link_out.rm   = link_in.rm | match_own;
        link_out.due  = link_in.due & due_own;
        link_out.wake = link_in.wake;
        // first entry left after a tick supplies the wake value
        if (link_in.due && !due_own && valid_reg)
        begin
            link_out.wake = link_in.wake | wake_reg;
        end
    end

    always_comb
    begin
        entry_next = entry;
        unique case (ctrl.op)
            stq_pkg::CELL_HOLD:
            begin
                entry_next = entry;
            end
            stq_pkg::CELL_INSERT:
            begin
                if (!le_own)
                begin
                    if (link_in.le)
                    begin
                        entry_next = '{valid: 1'b1, dl: ctrl.key_dl,
                                       wake: ctrl.key_wake, id: ctrl.key_id};
                    end
                    else
                    begin
                        entry_next = prev_entry;
                    end
                end
            end
            stq_pkg::CELL_REMOVE:
            begin
                if (link_out.rm)
                begin
                    entry_next = next_entry;
                end
            end
            stq_pkg::CELL_POP:
            begin
                entry_next = next_entry;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= entry_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        dl_reg   <= entry_next.dl;
        wake_reg <= entry_next.wake;
        id_reg   <= entry_next.id;
    end

endmodule

/* hdl/sorted_timer_event_queue.sv */
// Sorted timer event queue, top level: command FSM, divider and cell chain.
// Depends on stq_pkg, stq_div, stq_cell and assert_macros.svh.
//
// Usage: drive func, event_id, delay_us, now_ms with start high; the item is
// taken at the clock edge where start is high and busy is low. Results come
// back on status, fired_valid, fired_id, last and wakeup_ms, each valid for
// exactly one cycle while done is high; the receiver cannot hold them off.
// last marks the final result of an item.
// Sequence after the accepting edge (done rises with each result):
//   register : ST_DIV, ST_INS, then one result from ST_RESP (ST_DIV
//              covers the registered delay/1000 multiply and deadline sum)
//   cancel   : ST_CAN, then one result from ST_RESP
//   tick     : ST_TMUL, ST_TSCAN, then ST_TPOP, one result per cycle for
//              each expired event; the head cell pops one entry per cycle
//   other    : one result from ST_RESP
// A new item may be taken in the cycle its predecessor's last result shows.
// Entries live in a row of QUEUE_DEPTH cells kept sorted by deadline; each
// cell also stores deadline/1000, computed at register time.
// Reset empties the queue (cell valid bits clear) and idles the FSM.
`include "assert_macros.svh"

module sorted_timer_event_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [stq_pkg::FUNC_W-1:0]    func,
    input  logic [stq_pkg::ID_W-1:0]      event_id,
    input  logic [stq_pkg::DELAY_W-1:0]   delay_us,
    input  logic [stq_pkg::MS_W-1:0]      now_ms,
    output logic                          done,
    output logic [stq_pkg::STATUS_W-1:0]  status,
    output logic                          fired_valid,
    output logic [stq_pkg::ID_W-1:0]      fired_id,
    output logic                          last,
    output logic [stq_pkg::WAKE_W-1:0]    wakeup_ms
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_INS,
        ST_CAN,
        ST_TMUL,
        ST_TSCAN,
        ST_TPOP,
        ST_RESP
    } state_t;

    state_t                          state_reg;
    logic                            accept;

    // latched command
    logic [stq_pkg::ID_W-1:0]        id_reg;
    logic [stq_pkg::DELAY_W-1:0]     delay_reg;
    logic [stq_pkg::MS_W-1:0]        now_ms_reg;
    logic [stq_pkg::DL_W-1:0]        now_us_reg;
    logic [stq_pkg::DL_W-1:0]        key_reg;

    // result registers
    logic                            done_reg;
    logic [stq_pkg::STATUS_W-1:0]    status_reg;
    logic                            fired_valid_reg;
    logic [stq_pkg::ID_W-1:0]        fired_id_reg;
    logic                            last_reg;
    logic [stq_pkg::WAKE_W-1:0]      wakeup_reg;
    logic [stq_pkg::STATUS_W-1:0]    pend_status_reg;
    logic [stq_pkg::WAKE_W-1:0]      wake_fin_reg;

    // divider
    logic                            div_load;
    logic [stq_pkg::DELAY_W-1:0]     quotient;
    logic                            div_done;

    // cell chain
    stq_pkg::cell_ctrl_t             ctrl;
    stq_pkg::entry_t                 ent [stq_pkg::QUEUE_DEPTH];
    stq_pkg::link_t                  lnk [stq_pkg::QUEUE_DEPTH+1];
    stq_pkg::entry_t                 empty_entry;
    logic [stq_pkg::QUEUE_DEPTH-1:0] valid_vec;
    logic [stq_pkg::QUEUE_DEPTH-1:0] valid_inc;
    logic                            found;
    logic                            full;
    logic                            due0;
    logic                            due1;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign div_load = accept && (func == stq_pkg::FUNC_REGISTER);

    stq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .dividend (delay_us),
        .quotient (quotient),
        .done     (div_done)
    );

    // command payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg     <= event_id;
            delay_reg  <= delay_us;
            now_ms_reg <= now_ms;
        end
        // time in microseconds, then the new deadline; both have settled
        // by the cycle in which the insert or the tick scan reads them
        now_us_reg <= stq_pkg::DL_W'(now_ms_reg) * stq_pkg::DL_W'(stq_pkg::MS_TO_US);
        key_reg    <= now_us_reg + stq_pkg::DL_W'(delay_reg);
    end

    // ---------------------------------------------------------------
    // Cell chain. Head is cell 0; link 0 seeds the head's neighbor side.
    // ---------------------------------------------------------------
    assign empty_entry = '0;
    assign lnk[0]      = '{le: 1'b1, rm: 1'b0, due: 1'b1, wake: '0};

    generate
        for (genvar i = 0; i < stq_pkg::QUEUE_DEPTH; i++)
        begin : g_cell
            stq_pkg::entry_t prev_e;
            stq_pkg::entry_t next_e;
            if (i == 0)
            begin : g_head
                assign prev_e = empty_entry;
            end
            else
            begin : g_mid_prev
                assign prev_e = ent[i-1];
            end
            if (i == stq_pkg::QUEUE_DEPTH - 1)
            begin : g_tail
                assign next_e = empty_entry;
            end
            else
            begin : g_mid_next
                assign next_e = ent[i+1];
            end

            stq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .link_in    (lnk[i]),
                .link_out   (lnk[i+1]),
                .entry      (ent[i])
            );

            assign valid_vec[i] = ent[i].valid;
        end
    endgenerate

    assign found = lnk[stq_pkg::QUEUE_DEPTH].rm;
    assign full  = ent[stq_pkg::QUEUE_DEPTH-1].valid;
    assign due0  = lnk[1].due;
    assign due1  = lnk[2].due;

    // broadcast to the cells
    always_comb
    begin
        ctrl.op       = stq_pkg::CELL_HOLD;
        ctrl.key_dl   = key_reg;
        ctrl.key_wake = stq_pkg::WAKE_W'(now_ms_reg) + stq_pkg::WAKE_W'(quotient);
        ctrl.key_id   = id_reg;
        ctrl.now_us   = now_us_reg;
        unique case (state_reg)
            ST_INS:
            begin
                if (!found && !full)
                begin
                    ctrl.op = stq_pkg::CELL_INSERT;
                end
            end
            ST_CAN:
            begin
                if (found)
                begin
                    ctrl.op = stq_pkg::CELL_REMOVE;
                end
            end
            ST_TPOP:
            begin
                ctrl.op = stq_pkg::CELL_POP;
            end
            default:
            begin
                ctrl.op = stq_pkg::CELL_HOLD;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Command sequencer and result registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            done_reg        <= 1'b0;
            status_reg      <= '0;
            fired_valid_reg <= 1'b0;
            fired_id_reg    <= '0;
            last_reg        <= 1'b0;
            wakeup_reg      <= '0;
            pend_status_reg <= '0;
            wake_fin_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        pend_status_reg <= stq_pkg::STATUS_OK;
                        unique case (func)
                            stq_pkg::FUNC_REGISTER: state_reg <= ST_DIV;
                            stq_pkg::FUNC_CANCEL:   state_reg <= ST_CAN;
                            stq_pkg::FUNC_TICK:     state_reg <= ST_TMUL;
                            default:                state_reg <= ST_RESP;
                        endcase
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_INS;
                    end
                end
                ST_INS:
                begin
                    // duplicate check ranks ahead of the full check
                    if (found)
                    begin
                        pend_status_reg <= stq_pkg::STATUS_DUPLICATE;
                    end
                    else if (full)
                    begin
                        pend_status_reg <= stq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        pend_status_reg <= stq_pkg::STATUS_OK;
                    end
                    state_reg <= ST_RESP;
                end
                ST_CAN:
                begin
                    pend_status_reg <= found ? stq_pkg::STATUS_OK : stq_pkg::STATUS_NOT_FOUND;
                    state_reg       <= ST_RESP;
                end
                ST_TMUL:
                begin
                    state_reg <= ST_TSCAN;
                end
                ST_TSCAN:
                begin
                    wake_fin_reg <= lnk[stq_pkg::QUEUE_DEPTH].wake;
                    if (!due0)
                    begin
                        // nothing expired: single empty result
                        done_reg        <= 1'b1;
                        status_reg      <= stq_pkg::STATUS_OK;
                        fired_valid_reg <= 1'b0;
                        fired_id_reg    <= '0;
                        last_reg        <= 1'b1;
                        wakeup_reg      <= lnk[stq_pkg::QUEUE_DEPTH].wake;
                        state_reg       <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_TPOP;
                    end
                end
                ST_TPOP:
                begin
                    done_reg        <= 1'b1;
                    status_reg      <= stq_pkg::STATUS_OK;
                    fired_valid_reg <= 1'b1;
                    fired_id_reg    <= ent[0].id;
                    last_reg        <= !due1;
                    wakeup_reg      <= wake_fin_reg;
                    if (!due1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RESP:
                begin
                    done_reg        <= 1'b1;
                    status_reg      <= pend_status_reg;
                    fired_valid_reg <= 1'b0;
                    fired_id_reg    <= '0;
                    last_reg        <= 1'b1;
                    wakeup_reg      <= ent[0].valid ? ent[0].wake : '0;
                    state_reg       <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign fired_valid = fired_valid_reg;
    assign fired_id    = fired_id_reg;
    assign last        = last_reg;
    assign wakeup_ms   = wakeup_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    assign valid_inc = valid_vec + 1'b1;

    // occupied cells always form a run starting at the head
    `ASSERT_IMPLIES(a_valid_prefix, clk, rst_n, 1'b1, (valid_vec & valid_inc) == '0)
    // an insert is never issued into a full chain
    `ASSERT_IMPLIES(a_no_insert_full, clk, rst_n, ctrl.op == stq_pkg::CELL_INSERT, !full)
    // a result that is not the last one is followed by more work
    `ASSERT_IMPLIES(a_more_follow, clk, rst_n, done && !last, busy)
    // a pop always sees an expired head
    `ASSERT_IMPLIES(a_pop_due, clk, rst_n, state_reg == ST_TPOP, due0)

endmodule
